// File: design/klp_pkg.sv
// Shared types for the key/value line parser: result codes, parser states,
// the word handed to the parser and the result word. No dependencies.
`timescale 1ns / 1ps

package klp_pkg;

   localparam int IN_BYTE_W   = 8;
   localparam int KEY_LEN_W   = 9;
   localparam int VAL_LEN_W   = 13;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 2;

   typedef enum logic [2:0] {
      STAT_NONE     = 3'd0,
      STAT_PAIR     = 3'd1,
      STAT_COMPLETE = 3'd2,
      STAT_KEY_OVF  = 3'd3,
      STAT_VAL_OVF  = 3'd4,
      STAT_BAD_ESC  = 3'd5,
      STAT_BREAK    = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      PS_IDLE   = 4'd0,
      PS_KEY    = 4'd1,
      PS_SEP    = 4'd2,
      PS_BARE   = 4'd3,
      PS_QUOTED = 4'd4,
      PS_BSLASH = 4'd5,
      PS_HEX1   = 4'd6,
      PS_HEX2   = 4'd7,
      PS_AFTERQ = 4'd8
   } parse_state_type;

   typedef struct packed {
      logic                 valid;
      logic [IN_BYTE_W-1:0] in_byte;
   } in_step_type;

   typedef struct packed {
      logic [VAL_LEN_W-1:0] value_length;
      logic [KEY_LEN_W-1:0] key_length;
      logic [7:0]           append_char;
      logic                 append_to_value;
      logic                 append_valid;
      status_type           status;
   } result_type;

endpackage

// File: design/klp_in_stage.sv
// Input register of the key/value line parser: holds one byte word until the
// parser consumes it. Depends on klp_pkg.
`timescale 1ns / 1ps

module klp_in_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic [klp_pkg::IN_BYTE_W-1:0] req_tdata,
   output logic                          req_tready,
   input  logic                          pop,
   output klp_pkg::in_step_type          step
);

   logic                          valid_ff, valid_in;
   logic [klp_pkg::IN_BYTE_W-1:0] byte_ff, byte_in;

   // free when empty or emptied this cycle
   assign req_tready = !valid_ff || pop;

   always_comb begin
      valid_in = valid_ff && !pop;
      byte_in  = byte_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         byte_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign step.valid   = valid_ff;
   assign step.in_byte = byte_ff;

endmodule

// File: design/klp_parser.sv
// Parser state machine and key/value counters: one byte per step, result
// word built combinationally. Depends on klp_pkg.
`timescale 1ns / 1ps

module klp_parser #(
   parameter int KEY_CAPACITY   = 256,
   parameter int VALUE_CAPACITY = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [klp_pkg::IN_BYTE_W-1:0] in_byte,
   output klp_pkg::result_type           result
);

   localparam int KW = $clog2(KEY_CAPACITY + 1);
   localparam int VW = $clog2(VALUE_CAPACITY + 1);

   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_X_LO   = 8'h78;
   localparam logic [7:0] CH_X_UP   = 8'h58;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd70) ||
             (c >= 8'd97 && c <= 8'd102);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] d;
      if (c <= 8'd57) begin
         d = c - 8'd48;
      end else if (c <= 8'd70) begin
         d = c - 8'd55;
      end else begin
         d = c - 8'd87;
      end
      return d[3:0];
   endfunction

   klp_pkg::parse_state_type state_ff, state_in;
   logic [KW-1:0]            key_cnt_ff, key_cnt_in;
   logic [VW-1:0]            val_cnt_ff, val_cnt_in;
   logic [3:0]               nib_ff, nib_in;

   klp_pkg::status_type status;
   logic                append_valid, append_to_value;
   logic [7:0]          append_char;

   logic sp, sep, nl, key_full, val_full;

   assign nl       = in_byte == CH_NL;
   assign sp       = in_byte == CH_SPACE || in_byte == CH_TAB;
   assign sep      = sp || in_byte == CH_EQ;
   assign key_full = key_cnt_ff == KW'(KEY_CAPACITY);
   assign val_full = val_cnt_ff == VW'(VALUE_CAPACITY);

   // outputs, counters and escape nibble
   always_comb begin
      status          = klp_pkg::STAT_NONE;
      append_valid    = 1'b0;
      append_to_value = 1'b0;
      append_char     = 8'd0;
      key_cnt_in      = key_cnt_ff;
      val_cnt_in      = val_cnt_ff;
      nib_in          = nib_ff;
      case (state_ff)
         klp_pkg::PS_IDLE: begin
            key_cnt_in = '0;
            val_cnt_in = '0;
            if (nl) begin
               status = klp_pkg::STAT_COMPLETE;
            end else if (!sp) begin
               key_cnt_in   = KW'(1);
               append_valid = 1'b1;
               append_char  = in_byte;
            end
         end
         klp_pkg::PS_KEY: begin
            if (!sep) begin
               if (key_full) begin
                  status = klp_pkg::STAT_KEY_OVF;
               end else begin
                  key_cnt_in   = key_cnt_ff + KW'(1);
                  append_valid = 1'b1;
                  append_char  = in_byte;
               end
            end
         end
         klp_pkg::PS_SEP, klp_pkg::PS_BARE, klp_pkg::PS_QUOTED: begin
            if (state_ff == klp_pkg::PS_BARE && nl) begin
               status = klp_pkg::STAT_PAIR;
            end else if ((state_ff == klp_pkg::PS_SEP &&
                          (sep || in_byte == CH_QUOTE)) ||
                         (state_ff == klp_pkg::PS_QUOTED &&
                          (in_byte == CH_BSLASH || in_byte == CH_QUOTE))) begin
               status = klp_pkg::STAT_NONE;
            end else if (val_full) begin
               status = klp_pkg::STAT_VAL_OVF;
            end else begin
               val_cnt_in      = val_cnt_ff + VW'(1);
               append_valid    = 1'b1;
               append_to_value = 1'b1;
               append_char     = in_byte;
            end
         end
         klp_pkg::PS_BSLASH: begin
            if (in_byte != CH_X_LO && in_byte != CH_X_UP) begin
               status = klp_pkg::STAT_BAD_ESC;
            end
         end
         klp_pkg::PS_HEX1: begin
            if (is_hex(in_byte)) begin
               nib_in = hex_val(in_byte);
            end else begin
               status = klp_pkg::STAT_BAD_ESC;
            end
         end
         klp_pkg::PS_HEX2: begin
            if (!is_hex(in_byte)) begin
               status = klp_pkg::STAT_BAD_ESC;
            end else if (val_full) begin
               status = klp_pkg::STAT_VAL_OVF;
            end else begin
               val_cnt_in      = val_cnt_ff + VW'(1);
               append_valid    = 1'b1;
               append_to_value = 1'b1;
               append_char     = {nib_ff, hex_val(in_byte)};
            end
         end
         klp_pkg::PS_AFTERQ: begin
            status = nl ? klp_pkg::STAT_PAIR : klp_pkg::STAT_BREAK;
         end
         default: begin
            status = klp_pkg::STAT_NONE;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         klp_pkg::PS_IDLE: begin
            if (!nl && !sp) state_in = klp_pkg::PS_KEY;
         end
         klp_pkg::PS_KEY: begin
            if (sep) state_in = klp_pkg::PS_SEP;
         end
         klp_pkg::PS_SEP: begin
            if (in_byte == CH_QUOTE) begin
               state_in = klp_pkg::PS_QUOTED;
            end else if (!sep) begin
               state_in = klp_pkg::PS_BARE;
            end
         end
         klp_pkg::PS_BARE: begin
            state_in = klp_pkg::PS_BARE;
         end
         klp_pkg::PS_QUOTED: begin
            if (in_byte == CH_BSLASH) begin
               state_in = klp_pkg::PS_BSLASH;
            end else if (in_byte == CH_QUOTE) begin
               state_in = klp_pkg::PS_AFTERQ;
            end
         end
         klp_pkg::PS_BSLASH: state_in = klp_pkg::PS_HEX1;
         klp_pkg::PS_HEX1:   state_in = klp_pkg::PS_HEX2;
         klp_pkg::PS_HEX2:   state_in = klp_pkg::PS_QUOTED;
         default:            state_in = klp_pkg::PS_IDLE;
      endcase
      // any reported status ends the pair
      if (status != klp_pkg::STAT_NONE) state_in = klp_pkg::PS_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= klp_pkg::PS_IDLE;
         key_cnt_ff <= '0;
         val_cnt_ff <= '0;
         nib_ff     <= '0;
      end else if (step_en) begin
         state_ff   <= state_in;
         key_cnt_ff <= key_cnt_in;
         val_cnt_ff <= val_cnt_in;
         nib_ff     <= nib_in;
      end
   end

   assign result.status          = status;
   assign result.append_valid    = append_valid;
   assign result.append_to_value = append_to_value;
   assign result.append_char     = append_char;
   assign result.key_length      = klp_pkg::KEY_LEN_W'(key_cnt_in);
   assign result.value_length    = klp_pkg::VAL_LEN_W'(val_cnt_in);

endmodule

// File: design/klp_out_stage.sv
// Result register of the key/value line parser: holds a result word until the
// sink takes it. Depends on klp_pkg.
`timescale 1ns / 1ps

module klp_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                take,
   input  klp_pkg::result_type d,
   output logic                valid,
   output klp_pkg::result_type q
);

   logic                valid_ff, valid_in;
   klp_pkg::result_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff && !take;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign q     = data_ff;

endmodule

// File: design/key_value_line_parser_top.sv
// Top level of the key/value line parser: input register, parser and result
// register. Depends on klp_pkg, klp_in_stage, klp_parser, klp_out_stage.
`timescale 1ns / 1ps
//
//  Channel | Dir | Word contents
//  --------+-----+---------------------------------------------------------
//  req_    | in  | one raw text byte
//  rsp_    | out | status, appended character and both running lengths
//
//  One result word per byte word; one word per cycle sustained unless rsp_ stalls.
//  After req acceptance the byte sits in the input register; the parser step lands
//  in the result register once that register is free or being emptied.
//  Reset (synchronous, active high) empties both registers and returns the
//  parser to idle with both counts at zero.
//  A stalled rsp_ holds its word; the parser advances only when the result
//  register is free or being emptied, and req_tready drops while both the
//  input register and the result register are full and rsp_ is stalled.
//  Key and value characters are not stored, only counted.

module key_value_line_parser_top #(
   parameter int KEY_CAPACITY   = 256,
   parameter int VALUE_CAPACITY = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: [7:0] in_byte
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [klp_pkg::IN_BYTE_W-1:0]   req_tdata,
   // rsp_tdata: [2:0] status, [10:3] append_char, [19:11] key_length,
   //            [32:20] value_length, [39:33] zero
   // rsp_tuser: [0] append_valid, [1] append_to_value
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [klp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [klp_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   klp_pkg::in_step_type step;
   klp_pkg::result_type  result;
   klp_pkg::result_type  rsp_word;
   logic                 advance;

   // advance a byte into the parser when the result register can take it
   assign advance = step.valid && (!rsp_tvalid || rsp_tready);

   klp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tready (req_tready),
      .pop        (advance),
      .step       (step)
   );

   klp_parser #(
      .KEY_CAPACITY   (KEY_CAPACITY),
      .VALUE_CAPACITY (VALUE_CAPACITY)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .in_byte (step.in_byte),
      .result  (result)
   );

   klp_out_stage u_out (
      .clock (clock),
      .reset (reset),
      .load  (advance),
      .take  (rsp_tready),
      .d     (result),
      .valid (rsp_tvalid),
      .q     (rsp_word)
   );

   // pack the result word, highest field first
   assign rsp_tdata = {7'd0, rsp_word.value_length, rsp_word.key_length,
                       rsp_word.append_char, rsp_word.status};
   assign rsp_tuser = {rsp_word.append_to_value, rsp_word.append_valid};

endmodule

// File: design/klp_checker.sv
// Port-level checks for the key/value line parser, bound to the top level.
// Depends on klp_pkg and key_value_line_parser_top.
`timescale 1ns / 1ps

module klp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [klp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [klp_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   // no result word survives reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // no append: no value flag and a zero character
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> !rsp_tuser[1] && rsp_tdata[10:3] == 8'd0)
      else $error("append fields set without append_valid");

   // a word that reports a status never appends a character
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != klp_pkg::STAT_NONE |-> !rsp_tuser[0])
      else $error("append together with a status");

   // packet complete comes from idle, where both counts are cleared
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == klp_pkg::STAT_COMPLETE |->
         rsp_tdata[19:11] == 9'd0 && rsp_tdata[32:20] == 13'd0)
      else $error("packet complete with nonzero lengths");

endmodule

bind key_value_line_parser_top klp_checker u_klp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/key_value_line_parser_top_tb.sv
// Self-checking bench for key_value_line_parser_top: byte words in, one result word out per byte.
// Depends on klp_pkg and the design under design/. It predicts every result and compares
// each field.
`timescale 1ns / 1ps

module key_value_line_parser_top_tb;

   // Capacities as instantiated below; the predictor keeps its own copy.
   localparam int KEY_CAP   = 256;
   localparam int VALUE_CAP = 4096;

   // Characters that steer the parser.
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_X_LO   = 8'h78;
   localparam logic [7:0] CH_X_UP   = 8'h58;

   localparam int N_DIRECTED  = 28;
   localparam int RANDOM_BYTES = 950;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [klp_pkg::IN_BYTE_W-1:0]   req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b1;
   logic [klp_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [klp_pkg::RSP_TUSER_W-1:0] rsp_tuser;

   // One stimulus row: the byte and, where it is obvious, the result typed in by hand.
   typedef struct {
      logic [7:0]          in_byte;
      bit                  typed;
      klp_pkg::result_type want;
   } directed_row_type;

   directed_row_type directed_rows [N_DIRECTED];

   // Predictor state, advanced once per accepted byte word.
   klp_pkg::parse_state_type parse_state = klp_pkg::PS_IDLE;
   int unsigned              key_count   = 0;
   int unsigned              value_count = 0;
   logic [3:0]               high_nibble = '0;

   klp_pkg::result_type expected_results [$];
   int unsigned mismatches = 0;
   int unsigned bytes_sent = 0;
   bit          steady_run = 1'b0;   // no gaps on either side while set
   int unsigned rsp_hold   = 0;

   key_value_line_parser_top #(
      .KEY_CAPACITY   (KEY_CAP),
      .VALUE_CAPACITY (VALUE_CAP)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   function automatic bit hex_digit_ok(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction

   function automatic logic [3:0] hex_digit_value(input logic [7:0] c);
      logic [7:0] v;
      if (c <= "9") v = c - "0";
      else if (c <= "F") v = c - "A" + 8'd10;
      else v = c - "a" + 8'd10;
      return v[3:0];
   endfunction

   // Count a key character, or flag the overflow and drop it.
   function automatic void add_key_char(inout klp_pkg::result_type r, input logic [7:0] c);
      if (key_count >= KEY_CAP) begin
         r.status = klp_pkg::STAT_KEY_OVF;
      end else begin
         key_count++;
         r.append_valid    = 1'b1;
         r.append_to_value = 1'b0;
         r.append_char     = c;
      end
   endfunction

   function automatic void add_value_char(inout klp_pkg::result_type r, input logic [7:0] c);
      if (value_count >= VALUE_CAP) begin
         r.status = klp_pkg::STAT_VAL_OVF;
      end else begin
         value_count++;
         r.append_valid    = 1'b1;
         r.append_to_value = 1'b1;
         r.append_char     = c;
      end
   endfunction

   // Advance the parser by one byte and return the result word it must produce.
   function automatic klp_pkg::result_type parse_step(input logic [7:0] c);
      klp_pkg::result_type r;
      bit                  blank;
      bit                  separator;
      blank     = (c == CH_SPACE) || (c == CH_TAB);
      separator = blank || (c == CH_EQ);
      r = '0;
      case (parse_state)
         klp_pkg::PS_IDLE: begin
            // Every byte taken in idle starts a fresh line.
            key_count   = 0;
            value_count = 0;
            if (c == CH_LF) begin
               r.status = klp_pkg::STAT_COMPLETE;
            end else if (!blank) begin
               parse_state = klp_pkg::PS_KEY;
               add_key_char(r, c);
            end
         end
         klp_pkg::PS_KEY: begin
            if (separator) parse_state = klp_pkg::PS_SEP;
            else add_key_char(r, c);
         end
         klp_pkg::PS_SEP: begin
            if (separator) begin
               parse_state = klp_pkg::PS_SEP;
            end else if (c == CH_QUOTE) begin
               parse_state = klp_pkg::PS_QUOTED;
            end else begin
               parse_state = klp_pkg::PS_BARE;
               add_value_char(r, c);
            end
         end
         klp_pkg::PS_BARE: begin
            if (c == CH_LF) r.status = klp_pkg::STAT_PAIR;
            else add_value_char(r, c);
         end
         klp_pkg::PS_QUOTED: begin
            if (c == CH_BSLASH) parse_state = klp_pkg::PS_BSLASH;
            else if (c == CH_QUOTE) parse_state = klp_pkg::PS_AFTERQ;
            else add_value_char(r, c);
         end
         klp_pkg::PS_BSLASH: begin
            if (c == CH_X_LO || c == CH_X_UP) parse_state = klp_pkg::PS_HEX1;
            else r.status = klp_pkg::STAT_BAD_ESC;
         end
         klp_pkg::PS_HEX1: begin
            if (hex_digit_ok(c)) begin
               high_nibble = hex_digit_value(c);
               parse_state = klp_pkg::PS_HEX2;
            end else begin
               r.status = klp_pkg::STAT_BAD_ESC;
            end
         end
         klp_pkg::PS_HEX2: begin
            if (hex_digit_ok(c)) begin
               add_value_char(r, {high_nibble, hex_digit_value(c)});
               parse_state = klp_pkg::PS_QUOTED;
            end else begin
               r.status = klp_pkg::STAT_BAD_ESC;
            end
         end
         klp_pkg::PS_AFTERQ: begin
            r.status = (c == CH_LF) ? klp_pkg::STAT_PAIR : klp_pkg::STAT_BREAK;
         end
         default: parse_state = klp_pkg::PS_IDLE;
      endcase
      // Any status ends the line; the counts stay visible until the next idle byte.
      if (r.status != klp_pkg::STAT_NONE) parse_state = klp_pkg::PS_IDLE;
      r.key_length   = key_count[klp_pkg::KEY_LEN_W-1:0];
      r.value_length = value_count[klp_pkg::VAL_LEN_W-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      // Keep the log short if the design is badly broken.
      if (mismatches <= 50)
         $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
   endtask

   task automatic check_result(input logic [klp_pkg::RSP_TDATA_W-1:0] data,
                               input logic [klp_pkg::RSP_TUSER_W-1:0] user);
      klp_pkg::result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("unexpected result word, status", 32'(data[2:0]), '0);
         return;
      end
      want = expected_results.pop_front();
      if (data[2:0] !== want.status)
         report_mismatch("status", 32'(data[2:0]), 32'(want.status));
      if (user[0] !== want.append_valid)
         report_mismatch("append_valid", 32'(user[0]), 32'(want.append_valid));
      if (user[1] !== want.append_to_value)
         report_mismatch("append_to_value", 32'(user[1]), 32'(want.append_to_value));
      if (data[10:3] !== want.append_char)
         report_mismatch("append_char", 32'(data[10:3]), 32'(want.append_char));
      if (data[19:11] !== want.key_length)
         report_mismatch("key_length", 32'(data[19:11]), 32'(want.key_length));
      if (data[32:20] !== want.value_length)
         report_mismatch("value_length", 32'(data[32:20]), 32'(want.value_length));
      if (data[39:33] !== '0)
         report_mismatch("tdata padding", 32'(data[39:33]), '0);
   endtask

   // Take every result word the design hands over; sample before this edge's updates land.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result(rsp_tdata, rsp_tuser);
   end

   // Result side back-pressure: after each word taken, hold rsp_tready low for a random stall.
   always @(posedge clock) begin
      int unsigned stall;
      if (reset) begin
         rsp_tready <= 1'b1;
         rsp_hold   <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= (rsp_hold == 1);
      end else if (rsp_tvalid && rsp_tready) begin
         stall = steady_run ? 0 : $urandom_range(0, 3);
         rsp_hold   <= stall;
         rsp_tready <= (stall == 0);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // Offer one byte word after a random gap, wait for acceptance, then predict.
   // Leave tvalid high on return so that a back-to-back word needs no second assignment.
   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input klp_pkg::result_type typed_want = '0);
      int unsigned         gap;
      klp_pkg::result_type predicted;
      gap = steady_run ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = parse_step(b);
      expected_results.push_back(typed ? typed_want : predicted);
      bytes_sent++;
   endtask

   function automatic directed_row_type open_row(input logic [7:0] b);
      directed_row_type row;
      row.in_byte = b;
      row.typed   = 1'b0;
      row.want    = '0;
      return row;
   endfunction

   function automatic directed_row_type known_row(input logic [7:0] b,
                                                  input klp_pkg::status_type st,
                                                  input logic av, input logic atv,
                                                  input logic [7:0] ch, input int kl,
                                                  input int vl);
      directed_row_type row;
      row.in_byte              = b;
      row.typed                = 1'b1;
      row.want.status          = st;
      row.want.append_valid    = av;
      row.want.append_to_value = atv;
      row.want.append_char     = ch;
      row.want.key_length      = kl[klp_pkg::KEY_LEN_W-1:0];
      row.want.value_length    = vl[klp_pkg::VAL_LEN_W-1:0];
      return row;
   endfunction

   // Key character: never a separator, and never a newline when it opens the key.
   function automatic logic [7:0] random_key_char(input bit first);
      logic [7:0] c;
      if (!first && $urandom_range(0, 19) == 0) return CH_LF;
      do c = 8'($urandom_range(0, 255));
      while (c == CH_SPACE || c == CH_TAB || c == CH_EQ || (first && c == CH_LF));
      return c;
   endfunction

   function automatic logic [7:0] random_hex_char();
      int unsigned v;
      v = $urandom_range(0, 21);
      if (v < 10) return 8'("0" + v);
      if (v < 16) return 8'("a" + v - 10);
      return 8'("A" + v - 16);
   endfunction

   function automatic logic [7:0] random_non_hex();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (hex_digit_ok(c));
      return c;
   endfunction

   // Byte inside quotes that neither escapes nor closes.
   function automatic logic [7:0] random_quoted_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == CH_BSLASH || c == CH_QUOTE);
      return c;
   endfunction

   task automatic send_blanks(input int unsigned most);
      repeat ($urandom_range(0, most)) send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
   endtask

   task automatic send_key(input int unsigned len);
      for (int unsigned i = 0; i < len; i++) send_byte(random_key_char(i == 0));
   endtask

   task automatic send_separators();
      int unsigned pick;
      repeat ($urandom_range(1, 3)) begin
         pick = $urandom_range(0, 2);
         send_byte(pick == 0 ? CH_SPACE : (pick == 1 ? CH_TAB : CH_EQ));
      end
   endtask

   task automatic send_escape();
      send_byte(CH_BSLASH);
      send_byte($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
      send_byte(random_hex_char());
      send_byte(random_hex_char());
   endtask

   // One line of random content; mostly well formed, some broken, some pure noise.
   task automatic send_random_line();
      int unsigned kind;
      int unsigned len;
      logic [7:0]  c;
      kind = $urandom_range(0, 99);
      steady_run = ($urandom_range(0, 5) == 0);
      if (kind < 10) begin
         // empty line closes the packet
         send_blanks(2);
         send_byte(CH_LF);
      end else if (kind < 45) begin
         // bare value; its first byte may be a newline but not a separator or quote
         send_blanks(1);
         send_key($urandom_range(1, 6));
         send_separators();
         do c = 8'($urandom_range(0, 255));
         while (c == CH_SPACE || c == CH_TAB || c == CH_EQ || c == CH_QUOTE);
         send_byte(c);
         len = $urandom_range(0, 7);
         repeat (len) begin
            do c = 8'($urandom_range(0, 255));
            while (c == CH_LF);
            send_byte(c);
         end
         send_byte(CH_LF);
      end else if (kind < 78) begin
         // quoted value with escapes, usually closed by a newline
         send_blanks(1);
         send_key($urandom_range(1, 6));
         send_separators();
         send_byte(CH_QUOTE);
         repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 2) == 0) send_escape();
            else send_byte(random_quoted_char());
         end
         send_byte(CH_QUOTE);
         if ($urandom_range(0, 6) != 0) begin
            send_byte(CH_LF);
         end else begin
            do c = 8'($urandom_range(0, 255));
            while (c == CH_LF);
            send_byte(c);
         end
      end else if (kind < 90) begin
         // escape broken at the backslash, the first digit or the second digit
         send_key($urandom_range(1, 4));
         send_separators();
         send_byte(CH_QUOTE);
         if ($urandom_range(0, 1)) send_byte(random_quoted_char());
         send_byte(CH_BSLASH);
         case ($urandom_range(0, 2))
            0: begin
               do c = 8'($urandom_range(0, 255));
               while (c == CH_X_LO || c == CH_X_UP);
               send_byte(c);
            end
            1: begin
               send_byte(CH_X_LO);
               send_byte(random_non_hex());
            end
            default: begin
               send_byte(CH_X_UP);
               send_byte(random_hex_char());
               send_byte(random_non_hex());
            end
         endcase
      end else begin
         // raw noise over the whole byte range
         repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // Long line to reach the capacities; a quoted value ends on an escape so that the
   // decoded character is the one that overflows.
   task automatic send_long_pair(input int unsigned key_len, input int unsigned value_len,
                                 input bit quoted);
      logic [7:0] c;
      steady_run = $urandom_range(0, 1);
      send_key(key_len);
      if (value_len == 0) begin
         send_byte(CH_LF);
         return;
      end
      send_byte(CH_EQ);
      if (quoted) send_byte(CH_QUOTE);
      for (int unsigned i = 0; i < value_len; i++) begin
         if (quoted) begin
            send_byte(random_quoted_char());
         end else begin
            do c = 8'($urandom_range(0, 255));
            while (c == CH_LF || (i == 0 && (c == CH_SPACE || c == CH_TAB ||
                                             c == CH_EQ || c == CH_QUOTE)));
            send_byte(c);
         end
      end
      if (quoted) begin
         send_escape();
         send_byte(CH_QUOTE);
      end
      send_byte(CH_LF);
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------

   initial begin
      int unsigned random_start;

      // Hand-typed rows: packet end, skipped blank, top byte opening a key, and two of the
      // ways a line can fail; the rows between them are left to the predictor.
      directed_rows = '{
         // newline in idle, blank skipped, 0xFF opens a key
         known_row(CH_LF, klp_pkg::STAT_COMPLETE, 1'b0, 1'b0, 8'h00, 0, 0),
         known_row(CH_SPACE, klp_pkg::STAT_NONE, 1'b0, 1'b0, 8'h00, 0, 0),
         known_row(8'hFF, klp_pkg::STAT_NONE, 1'b1, 1'b0, 8'hFF, 1, 0),
         // newline inside a key, separators, newline opening a bare value, zero byte
         open_row(CH_LF), open_row(CH_EQ), open_row(CH_TAB), open_row(CH_LF),
         open_row(8'h00), open_row(CH_LF),
         // quoted value with both escape cases, then junk after the closing quote
         known_row("k", klp_pkg::STAT_NONE, 1'b1, 1'b0, "k", 1, 0),
         open_row(CH_SPACE), open_row(CH_QUOTE), open_row(CH_BSLASH), open_row(CH_X_UP),
         open_row("f"), open_row("F"), open_row(CH_BSLASH), open_row(CH_X_LO),
         open_row("0"), open_row("9"), open_row(CH_QUOTE),
         known_row("!", klp_pkg::STAT_BREAK, 1'b0, 1'b0, 8'h00, 1, 2),
         // first hex digit just outside the range
         known_row("r", klp_pkg::STAT_NONE, 1'b1, 1'b0, "r", 1, 0),
         open_row(CH_EQ), open_row(CH_QUOTE), open_row(CH_BSLASH), open_row(CH_X_LO),
         known_row("g", klp_pkg::STAT_BAD_ESC, 1'b0, 1'b0, 8'h00, 1, 0)
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with gaps on both sides.
      for (int i = 0; i < N_DIRECTED; i++)
         send_byte(directed_rows[i].in_byte, directed_rows[i].typed, directed_rows[i].want);

      // Capacity extremes: full key closing a pair, one key byte too many,
      // plain value one too many, full quoted value plus one decoded escape.
      send_long_pair(KEY_CAP, 3, 1'b0);
      send_long_pair(KEY_CAP + 1, 0, 1'b0);
      send_long_pair(2, VALUE_CAP + 1, 1'b0);
      send_long_pair(1, VALUE_CAP, 1'b1);

      // Random lines until the byte budget is spent.
      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_BYTES) send_random_line();

      req_tvalid <= 1'b0;
      steady_run = 1'b0;

      // Drain outstanding results, then idle for any stray word.
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0) begin
         $display("key_value_line_parser_top verification clean");
      end else begin
         $display("key_value_line_parser_top verification failed");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run of roughly ten thousand byte words.
   initial begin
      #5_000_000;
      $display("key_value_line_parser_top verification failed");
      $finish;
   end

endmodule

// File: filelist.f
design/klp_pkg.sv
design/klp_in_stage.sv
design/klp_parser.sv
design/klp_out_stage.sv
design/key_value_line_parser_top.sv
design/klp_checker.sv
tb/key_value_line_parser_top_tb.sv
